[src/rtc_pkg.sv]
// Package with shared types, constants and codes for the transform composer.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

  // Fixed-point format of every matrix entry (signed Q16.16).
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Product, truncated product and accumulator widths.
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int TRUNC_W = PROD_W - FRAC_BITS;
  localparam int ACC_W   = TRUNC_W + 2;

  // Column codes.
  localparam logic [1:0] COL_X      = 2'd0;
  localparam logic [1:0] COL_Y      = 2'd1;
  localparam logic [1:0] COL_Z      = 2'd2;
  localparam logic [1:0] COL_ORIGIN = 2'd3;

  // Input transaction: one column of each source matrix.
  typedef struct packed {
    logic [1:0]                   column_index;
    logic signed [DATA_WIDTH-1:0] a_x;
    logic signed [DATA_WIDTH-1:0] a_y;
    logic signed [DATA_WIDTH-1:0] a_z;
    logic signed [DATA_WIDTH-1:0] b_x;
    logic signed [DATA_WIDTH-1:0] b_y;
    logic signed [DATA_WIDTH-1:0] b_z;
  } rtc_in_t;

  // Output transaction: one column of the composed matrix.
  typedef struct packed {
    logic [1:0]                   out_column;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic                         is_last;
  } rtc_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_LOAD
  } rtc_state_t;

  // Accumulator operations.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_FIRST,
    ACC_ADD
  } rtc_acc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        wr_axis;
    logic        cap_origin;
    logic        mul_en;
    logic [1:0]  k;
    logic [1:0]  j;
    rtc_acc_op_t acc_op;
    logic        out_load;
  } rtc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } rtc_sts_t;

endpackage

`default_nettype wire

[src/rigid_transform_compose.sv]
// Top level of the 4x4 homogeneous transform composer.
//
// Channels: the input channel (in_valid, in_ready, in_data) carries one column of each of
// the two source matrices per transaction. Axis columns 0 to 2 are stored and produce no
// output; the origin column (3) starts the composition C = A * B. The output channel
// (out_valid, out_ready, out_data) then carries C's columns 0, 1, 2 and 3, with is_last
// set on column 3.
// Sequence: an axis transaction is stored when it is accepted. After an origin
// transaction each output column passes through the ST_MUL state for each of its three
// terms on the three multiplier lanes (one term per row and cycle), ST_ACC to finish the
// sum and ST_LOAD to saturate it into the output register. No new input is accepted
// until all four columns have been loaded.
// in_ready is high only while no composition is in progress; the last result may still
// wait in the output register while new axis columns are taken.
// Reset (rst_n low, synchronous) returns the controller to idle and clears out_valid;
// the column stores are not cleared and must be written before an origin column.
// When the receiver stalls, the finished column holds in the output register and the
// computation waits before loading the next one.
`timescale 1ns / 1ps
`default_nettype none

module rigid_transform_compose (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rtc_pkg::rtc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rtc_pkg::rtc_out_t     out_data
);

  rtc_pkg::rtc_cmd_t cmd;
  rtc_pkg::rtc_sts_t sts;

  rtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_column (in_data.column_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An origin transaction starts the sequence at the first term of column 0.
  a_origin_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.column_index == rtc_pkg::COL_ORIGIN) |=>
    (cmd.mul_en && cmd.k == rtc_pkg::COL_X && cmd.j == rtc_pkg::COL_X))
    else $error("composition did not start at column 0 term 0");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while pending");

  // A loaded column appears on the output with the column number it was computed for.
  a_out_column: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_valid && out_data.out_column == $past(cmd.j)))
    else $error("output column does not match the computed column");

endmodule

`default_nettype wire

[src/rtc_ctrl.sv]
// Controller state machine that sequences the column products of the composition.
`timescale 1ns / 1ps
`default_nettype none

module rtc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_column,
  input  wire rtc_pkg::rtc_sts_t sts,
  output rtc_pkg::rtc_cmd_t  cmd
);

  rtc_pkg::rtc_state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] j_r, j_nxt;

  // State, term and column counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtc_pkg::ST_IDLE;
      k_r     <= rtc_pkg::COL_X;
      j_r     <= rtc_pkg::COL_X;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.k          = k_r;
    cmd.j          = j_r;
    cmd.acc_op     = rtc_pkg::ACC_HOLD;
    unique case (state_r)
      rtc_pkg::ST_IDLE: begin
        // The input is always ready here, so a valid transaction is accepted.
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_column == rtc_pkg::COL_ORIGIN) begin
            cmd.cap_origin = 1'b1;
            state_nxt      = rtc_pkg::ST_MUL;
            k_nxt          = rtc_pkg::COL_X;
            j_nxt          = rtc_pkg::COL_X;
          end else begin
            cmd.wr_axis = 1'b1;
          end
        end
      end
      rtc_pkg::ST_MUL: begin
        // From the second term on, the product of the previous term is accumulated while the next one multiplies.
        cmd.mul_en = 1'b1;
        if (k_r == rtc_pkg::COL_X) begin
          cmd.acc_op = rtc_pkg::ACC_HOLD;
        end else if (k_r == rtc_pkg::COL_Z) begin
          cmd.acc_op = rtc_pkg::ACC_ADD;
        end else begin
          cmd.acc_op = rtc_pkg::ACC_FIRST;
        end
        if (k_r == rtc_pkg::COL_Z) begin
          state_nxt = rtc_pkg::ST_ACC;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      rtc_pkg::ST_ACC: begin
        cmd.acc_op = rtc_pkg::ACC_ADD;
        state_nxt  = rtc_pkg::ST_LOAD;
      end
      rtc_pkg::ST_LOAD: begin
        // Wait until the output register is free, then hand off the column.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          k_nxt        = rtc_pkg::COL_X;
          if (j_r == rtc_pkg::COL_ORIGIN) begin
            state_nxt = rtc_pkg::ST_IDLE;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = rtc_pkg::ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = rtc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/rtc_datapath.sv]
// Datapath with column stores, three multiplier lanes, accumulators and output register.
`timescale 1ns / 1ps
`default_nettype none

module rtc_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rtc_pkg::rtc_in_t  in_data,
  input  wire rtc_pkg::rtc_cmd_t cmd,
  output rtc_pkg::rtc_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rtc_pkg::rtc_out_t      out_data
);

  localparam int DW = rtc_pkg::DATA_WIDTH;

  // Axis stores indexed [column][row]; origin column of each matrix.
  logic [DW-1:0] a_store_r [3][3];
  logic [DW-1:0] b_store_r [3][3];
  logic [DW-1:0] a_orig_r  [3];
  logic [DW-1:0] b_orig_r  [3];

  logic signed [rtc_pkg::PROD_W-1:0] prod_r   [3];
  logic signed [rtc_pkg::ACC_W-1:0]  acc_r    [3];
  logic signed [rtc_pkg::ACC_W-1:0]  acc_nxt  [3];
  logic signed [DW-1:0]              b_term;
  logic [DW-1:0]                     in_a [3];
  logic [DW-1:0]                     in_b [3];
  logic                              out_valid_r;
  rtc_pkg::rtc_out_t                 out_data_r;

  // Clamp an accumulated sum to the signed data range.
  function automatic logic [DW-1:0] sat(input logic signed [rtc_pkg::ACC_W-1:0] v);
    logic [DW-1:0] res;
    if (v[rtc_pkg::ACC_W-1:DW-1] == '0 || v[rtc_pkg::ACC_W-1:DW-1] == '1) begin
      res = v[DW-1:0];
    end else if (v[rtc_pkg::ACC_W-1]) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

  assign in_a[0] = in_data.a_x;
  assign in_a[1] = in_data.a_y;
  assign in_a[2] = in_data.a_z;
  assign in_b[0] = in_data.b_x;
  assign in_b[1] = in_data.b_y;
  assign in_b[2] = in_data.b_z;

  // Column stores: axis columns on axis transactions, origin on the origin transaction.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (cmd.wr_axis) begin
        a_store_r[in_data.column_index][r] <= in_a[r];
        b_store_r[in_data.column_index][r] <= in_b[r];
      end
      if (cmd.cap_origin) begin
        a_orig_r[r] <= in_a[r];
        b_orig_r[r] <= in_b[r];
      end
    end
  end

  // Second-matrix entry for term k of column j; the origin column comes from its register.
  always_comb begin
    if (cmd.j == rtc_pkg::COL_ORIGIN) begin
      b_term = b_orig_r[cmd.k];
    end else begin
      b_term = b_store_r[cmd.j][cmd.k];
    end
  end

  // One product per row lane, registered before accumulation.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r] <= $signed(a_store_r[cmd.k][r]) * b_term;
      end
    end
  end

  // Accumulate floor-truncated products; the origin column also adds the first origin.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic signed [rtc_pkg::ACC_W-1:0] term;
      logic signed [rtc_pkg::ACC_W-1:0] addend;
      term = {{(rtc_pkg::ACC_W - rtc_pkg::TRUNC_W){prod_r[r][rtc_pkg::PROD_W-1]}},
              prod_r[r][rtc_pkg::PROD_W-1:rtc_pkg::FRAC_BITS]};
      addend = {{(rtc_pkg::ACC_W - DW){a_orig_r[r][DW-1]}}, a_orig_r[r]};
      unique case (cmd.acc_op)
        rtc_pkg::ACC_FIRST: begin
          acc_nxt[r] = (cmd.j == rtc_pkg::COL_ORIGIN) ? term + addend : term;
        end
        rtc_pkg::ACC_ADD: begin
          acc_nxt[r] = acc_r[r] + term;
        end
        default: begin
          acc_nxt[r] = acc_r[r];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      acc_r[r] <= acc_nxt[r];
    end
  end

  // Output register; a pending transaction leaves when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.out_column <= cmd.j;
      out_data_r.out_x      <= sat(acc_r[0]);
      out_data_r.out_y      <= sat(acc_r[1]);
      out_data_r.out_z      <= sat(acc_r[2]);
      out_data_r.is_last    <= (cmd.j == rtc_pkg::COL_ORIGIN);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire
